// File: rtl/dpm_pkg.sv
// Shared types and constants for the binary64 multiplier.
package dpm_pkg;

    localparam logic [12:0] BIAS        = 13'd1023;
    localparam logic [10:0] EXP_ONES    = 11'h7FF;
    localparam logic [51:0] HALF_ULP    = 52'h8_0000_0000_0000;
    localparam logic [6:0]  ALIGN_TOP   = 7'd105;
    localparam int unsigned MANT_W      = 53;
    localparam int unsigned PROD_W      = 106;
    localparam int unsigned LO_W        = 27;
    localparam int unsigned HI_W        = MANT_W - LO_W;
    localparam int unsigned CHUNK_W     = 8;
    localparam int unsigned NUM_CHUNKS  = 13;

    // Per-request control that does not depend on the mantissa product.
    typedef struct packed {
        logic [12:0] exp_ab;
        logic        sub_in;
        logic        sign;
        logic        nan_any;
        logic        zero_any;
        logic [10:0] spec_exp;
        logic [51:0] spec_mant;
    } t_ctl;

    // One classified request as it travels through the queue.
    typedef struct packed {
        logic [52:0] mant_a;
        logic [52:0] mant_b;
        t_ctl        ctl;
    } t_op;

endpackage

// File: rtl/dpm_front.sv
// Front end: accepts requests, unpacks and classifies both operands.
module dpm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [63:0]   i_operand_a,
    input  logic [63:0]   i_operand_b,
    input  logic          i_q_full,
    output logic          o_q_push,
    output dpm_pkg::t_op  o_q_data
);
    import dpm_pkg::*;

    logic        r_fv, n_fv;
    t_op         r_op, n_op;
    logic        accept;
    logic        sa, sb, zero_a, zero_b, mz_a, mz_b, nan_a, nan_b;
    logic [10:0] ea, eb;

    assign o_stall  = r_fv && i_q_full;
    assign accept   = i_valid && !o_stall;
    assign o_q_push = r_fv && !i_q_full;
    assign o_q_data = r_op;

    // Field extraction and operand classes.
    always_comb begin
        sa     = i_operand_a[63];
        sb     = i_operand_b[63];
        ea     = i_operand_a[62:52];
        eb     = i_operand_b[62:52];
        zero_a = (i_operand_a[62:0] == 63'd0);
        zero_b = (i_operand_b[62:0] == 63'd0);
        mz_a   = (i_operand_a[51:0] == 52'd0);
        mz_b   = (i_operand_b[51:0] == 52'd0);
        nan_a  = (ea == EXP_ONES);
        nan_b  = (eb == EXP_ONES);
    end

    // Build the classified request.
    always_comb begin
        n_op.mant_a       = {(ea != 11'd0), i_operand_a[51:0]};
        n_op.mant_b       = {(eb != 11'd0), i_operand_b[51:0]};
        n_op.ctl.exp_ab   = {2'b00, ea} + {2'b00, eb} - BIAS;
        n_op.ctl.sub_in   = (ea == 11'd0) || (eb == 11'd0);
        n_op.ctl.nan_any  = nan_a || nan_b;
        n_op.ctl.zero_any = zero_a || zero_b;
        n_op.ctl.spec_exp = nan_a ? ea : eb;

        // Sign: infinity times zero first, then NaN payload owners.
        priority if ((nan_a && mz_a && zero_b) || (nan_b && mz_b && zero_a)) begin
            n_op.ctl.sign = 1'b1;
        end else if (nan_a && !mz_a) begin
            n_op.ctl.sign = sa || sb;
        end else if (nan_b && !mz_b) begin
            n_op.ctl.sign = sb;
        end else begin
            n_op.ctl.sign = sa ^ sb;
        end

        // Mantissa for NaN and infinity operands.
        priority if ((nan_a && mz_a && !mz_b) || (nan_b && mz_b && !mz_a)) begin
            n_op.ctl.spec_mant = 52'd0;
        end else if (nan_a && !(nan_b && sb)) begin
            n_op.ctl.spec_mant = HALF_ULP | {1'b0, i_operand_a[50:0]};
        end else begin
            n_op.ctl.spec_mant = HALF_ULP | {1'b0, i_operand_b[50:0]};
        end
    end

    // Holding register valid flag.
    always_comb begin
        priority if (accept) begin
            n_fv = 1'b1;
        end else if (o_q_push) begin
            n_fv = 1'b0;
        end else begin
            n_fv = r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

// File: rtl/dpm_queue.sv
// Short request queue between the front end and the arithmetic pipeline.
module dpm_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dpm_pkg::t_op  i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output dpm_pkg::t_op  o_data
);
    import dpm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // Pointer wrap and occupancy.
    always_comb begin
        n_wr  = i_push ? ((r_wr == LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd  = do_pop ? ((r_rd == LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/dpm_back.sv
// Arithmetic pipeline: multiply, normalize, post-shift, round and pack.
module dpm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  dpm_pkg::t_op  i_q_data,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [63:0]   o_product,
    output logic          o_illegal_operand,
    output logic          o_exponent_overflow
);
    import dpm_pkg::*;

    // Leading zeros of one byte, eight when the byte is zero.
    function automatic logic [3:0] lz8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                n = 4'(7 - i);
            end
        end
        return n;
    endfunction

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_ov;

    // Stage 1: partial products.
    logic [2*LO_W-1:0]      r_pp00;
    logic [LO_W+HI_W-1:0]   r_pp01, r_pp10;
    logic [2*HI_W-1:0]      r_pp11;
    t_ctl                   r_c1;
    // Stage 2: full product.
    logic [PROD_W-1:0]      r_p2;
    t_ctl                   r_c2;
    // Stage 3: per-byte leading zero counts.
    logic [PROD_W-1:0]      r_p3;
    logic [3:0]             r_lz [NUM_CHUNKS];
    t_ctl                   r_c3;
    // Stage 4: normalize shift amount.
    logic [PROD_W-1:0]      r_p4;
    logic [6:0]             r_sh4;
    t_ctl                   r_c4;
    // Stage 5: aligned mantissa and exponent.
    logic [104:0]           r_al5;
    logic [12:0]            r_exp5;
    logic [11:0]            r_post5;
    logic                   r_ovf5;
    t_ctl                   r_c5;
    // Stage 6: post-shifted mantissa.
    logic [104:0]           r_m6;
    logic [12:0]            r_exp6;
    logic                   r_ovf6;
    t_ctl                   r_c6;
    // Output register.
    logic [63:0]            r_product;
    logic                   r_ill, r_ovf;

    assign en      = !(r_ov && i_stall);
    assign o_q_pop = en && i_q_valid;

    assign o_valid             = r_ov;
    assign o_product           = r_product;
    assign o_illegal_operand   = r_ill;
    assign o_exponent_overflow = r_ovf;

    // Valid chain; the whole pipeline holds while the result waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_q_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_ov <= r_v6;
        end
    end

    // Stage 2 sum of partial products.
    logic [PROD_W-1:0] n_p2;
    always_comb begin
        n_p2 = PROD_W'(r_pp00)
             + ((PROD_W'(r_pp01) + PROD_W'(r_pp10)) << LO_W)
             + (PROD_W'(r_pp11) << (2 * LO_W));
    end

    // Stage 4 priority over the byte counts; the first nonzero byte wins.
    logic [6:0] n_sh4;
    always_comb begin
        n_sh4 = 7'd0;
        if (!r_p3[105] && !r_p3[104]) begin
            for (int k = NUM_CHUNKS - 1; k >= 0; k--) begin
                if (r_lz[k] != 4'd8) begin
                    n_sh4 = 7'(k * CHUNK_W) + {3'b000, r_lz[k]} + 7'd1;
                end
            end
        end
    end

    // Stage 5 alignment, exponent and subnormal post-shift.
    logic [104:0] n_al5;
    logic [PROD_W-1:0] shl;
    logic [12:0]  n_exp5;
    logic [11:0]  n_post5;
    logic         p105, neg5;
    always_comb begin
        p105   = r_p4[105];
        shl    = r_p4 << r_sh4;
        n_al5  = p105 ? r_p4[105:1] : shl[104:0];
        n_exp5 = r_c4.exp_ab + {12'd0, p105 || r_c4.sub_in} - {6'd0, r_sh4};
        neg5   = n_exp5[12];
        n_post5 = 12'd0;
        if (neg5 || n_exp5 == 13'd0) begin
            n_post5 = ~n_exp5[11:0]
                    + ((r_sh4 == 7'd0 || p105 || r_c4.sub_in) ? 12'd2 : 12'd1);
        end
    end

    // Stage 6 right shift into subnormal range.
    logic [104:0] n_m6;
    always_comb begin
        if (r_post5 >= {5'd0, ALIGN_TOP}) begin
            n_m6 = '0;
        end else begin
            n_m6 = r_al5 >> r_post5[6:0];
        end
    end

    // Final rounding, to nearest with ties to even, and packing.
    logic [52:0] mshort;
    logic        rnd, ones;
    logic [10:0] res_exp;
    logic [51:0] res_mant;
    always_comb begin
        mshort = r_m6[104:52];
        ones   = &mshort;
        rnd    = r_m6[51] && !((r_m6[51:0] == HALF_ULP) && !mshort[0]);
        priority if (r_c6.nan_any) begin
            res_exp = r_c6.spec_exp;
        end else if (r_exp6[12] || r_c6.zero_any) begin
            res_exp = 11'd0;
        end else if (r_ovf6) begin
            res_exp = EXP_ONES;
        end else begin
            res_exp = r_exp6[10:0] + {10'd0, ones && rnd};
        end
        priority if (r_c6.nan_any) begin
            res_mant = r_c6.spec_mant;
        end else if (r_ovf6) begin
            res_mant = 52'd0;
        end else begin
            res_mant = mshort[51:0] + {51'd0, rnd};
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pp00 <= i_q_data.mant_a[LO_W-1:0] * i_q_data.mant_b[LO_W-1:0];
            r_pp01 <= i_q_data.mant_a[LO_W-1:0] * i_q_data.mant_b[MANT_W-1:LO_W];
            r_pp10 <= i_q_data.mant_a[MANT_W-1:LO_W] * i_q_data.mant_b[LO_W-1:0];
            r_pp11 <= i_q_data.mant_a[MANT_W-1:LO_W] * i_q_data.mant_b[MANT_W-1:LO_W];
            r_c1   <= i_q_data.ctl;

            r_p2   <= n_p2;
            r_c2   <= r_c1;

            r_p3   <= r_p2;
            for (int k = 0; k < NUM_CHUNKS; k++) begin
                r_lz[k] <= lz8(r_p2[103 - k*CHUNK_W -: CHUNK_W]);
            end
            r_c3   <= r_c2;

            r_p4   <= r_p3;
            r_sh4  <= n_sh4;
            r_c4   <= r_c3;

            r_al5   <= n_al5;
            r_exp5  <= n_exp5;
            r_post5 <= n_post5;
            r_ovf5  <= !neg5 && (n_exp5 >= {2'b00, EXP_ONES});
            r_c5    <= r_c4;

            r_m6   <= n_m6;
            r_exp6 <= r_exp5;
            r_ovf6 <= r_ovf5;
            r_c6   <= r_c5;

            r_product <= {r_c6.sign, res_exp, res_mant};
            r_ill     <= r_c6.nan_any;
            r_ovf     <= r_ovf6;
        end
    end

endmodule

// File: rtl/double_precision_multiplier.sv
// Top level of the pipelined binary64 multiplier.
//
//   channel   valid      stall      payload
//   request   i_valid    o_stall    i_operand_a, i_operand_b
//   result    o_valid    i_stall    o_product, o_illegal_operand, o_exponent_overflow
//
// One request is accepted per cycle while o_stall is low; each result passes through
// the front register, the queue and seven pipeline stages before it appears.
// The 53x53 multiply is split into four partial products over two stages,
// and the normalize shift search takes two more stages.
// Reset is synchronous and active low; it empties the front, queue and pipeline.
// A stalled result freezes the pipeline; the queue keeps taking requests until full.
module double_precision_multiplier #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_product,
    output logic        o_illegal_operand,
    output logic        o_exponent_overflow
);
    import dpm_pkg::*;

    logic q_push, q_full, q_pop, q_valid;
    t_op  q_in, q_out;

    dpm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    dpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    dpm_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_data            (q_out),
        .o_q_pop             (q_pop),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_product           (o_product),
        .o_illegal_operand   (o_illegal_operand),
        .o_exponent_overflow (o_exponent_overflow)
    );

endmodule
